/* sv/running_sample_statistics_defines.svh */
// Assertion macros shared by the running sample statistics RTL.
`ifndef RUNNING_SAMPLE_STATISTICS_DEFINES_SVH
`define RUNNING_SAMPLE_STATISTICS_DEFINES_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define RSS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);
// Consequent holds in the same cycle as the antecedent.
`define RSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define RSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define RSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/rss_pkg.sv */
// Shared constants, widths, state and command types of the running sample statistics block.
package rss_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int MAX_COUNT = 65536;
    localparam int FRAC_BITS = 8;

    localparam int LOG_COUNT = $clog2(MAX_COUNT);
    localparam int COUNT_W   = $clog2(MAX_COUNT + 1);
    localparam int SUM_W     = SAMPLE_W + LOG_COUNT;
    localparam int SQ_W      = 2 * SAMPLE_W - 1 + LOG_COUNT;
    localparam int MEAN_W    = SAMPLE_W + FRAC_BITS;
    localparam int VAR_W     = 2 * SAMPLE_W - 1 + FRAC_BITS;
    localparam int DEV_W     = (VAR_W + FRAC_BITS + 1) / 2;

    // Split of the square sum for the count multiply
    localparam int SQ_LO_W = (SQ_W + 1) / 2;
    localparam int SQ_HI_W = SQ_W - SQ_LO_W;
    localparam int PLO_W   = COUNT_W + SQ_LO_W;
    localparam int PHI_W   = COUNT_W + SQ_HI_W;
    localparam int SQR_W   = 2 * SUM_W;
    localparam int NSS_W   = COUNT_W + SQ_W;
    localparam int DIFF_W  = (NSS_W > SQR_W) ? NSS_W : SQR_W;
    localparam int N2_W    = 2 * COUNT_W;

    // Shared divider
    localparam int DVD_W     = DIFF_W + FRAC_BITS;
    localparam int DVS_W     = N2_W;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    // Root unit
    localparam int ROOT_IN_W  = 2 * DEV_W;
    localparam int ROOT_REM_W = DEV_W + 2;
    localparam int ROOT_CNT_W = $clog2(DEV_W);

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_PREP,
        ST_MUL,
        ST_ADD,
        ST_SUB,
        ST_MEAN,
        ST_VAR,
        ST_ROOT
    } t_state;

    typedef enum logic {
        DIV_MEAN,
        DIV_VAR
    } t_div_sel;

    typedef struct packed {
        logic     accum;
        logic     snap;
        logic     prep;
        logic     mul;
        logic     add;
        logic     sub;
        logic     div_start;
        t_div_sel div_sel;
        logic     take_mean;
        logic     take_var;
        logic     sqrt_start;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
    } t_status;

endpackage

/* sv/rss_divider.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module rss_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rss_pkg::DVD_W-1:0] i_dividend,
    input  logic [rss_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [rss_pkg::DVD_W-1:0] o_quotient
);
    import rss_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVD_W-1:0]     r_quo;

    logic [DVS_W:0]   w_shifted;
    logic [DVS_W+1:0] w_diff;
    logic             w_borrow;

    assign w_shifted = {r_rem, r_quo[DVD_W-1]};
    assign w_diff    = {1'b0, w_shifted} - {2'b00, r_dvs};
    assign w_borrow  = w_diff[DVS_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DVD_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Shift the dividend out at the top, the quotient in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (w_borrow) begin
                r_rem <= w_shifted[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end else begin
                r_rem <= w_diff[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

/* sv/rss_sqrt.sv */
// Digit-by-digit floor square root of the scaled variance, one root bit per cycle.
module rss_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rss_pkg::VAR_W-1:0] i_radicand,
    output logic                      o_busy,
    output logic [rss_pkg::DEV_W-1:0] o_root
);
    import rss_pkg::*;

    logic                  r_busy;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic [ROOT_IN_W-1:0]  r_x;
    logic [ROOT_REM_W-1:0] r_rem;
    logic [DEV_W-1:0]      r_root;

    logic [ROOT_REM_W+1:0] w_rem_sh;
    logic [ROOT_REM_W+1:0] w_trial;
    logic [ROOT_REM_W+2:0] w_diff;
    logic                  w_borrow;

    assign w_rem_sh = {r_rem, r_x[ROOT_IN_W-1 -: 2]};
    assign w_trial  = (ROOT_REM_W + 2)'({r_root, 2'b01});
    assign w_diff   = {1'b0, w_rem_sh} - {1'b0, w_trial};
    assign w_borrow = w_diff[ROOT_REM_W+2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= ROOT_CNT_W'(DEV_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - ROOT_CNT_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Bring down two radicand bits a step, keep the trial subtract when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= ROOT_IN_W'(i_radicand) << FRAC_BITS;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= r_x << 2;
            if (w_borrow) begin
                r_rem  <= w_rem_sh[ROOT_REM_W-1:0];
                r_root <= {r_root[DEV_W-2:0], 1'b0};
            end else begin
                r_rem  <= w_diff[ROOT_REM_W-1:0];
                r_root <= {r_root[DEV_W-2:0], 1'b1};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

/* sv/rss_datapath.sv */
// Datapath: run accumulators, final statistics arithmetic and result register.
`include "running_sample_statistics_defines.svh"
module rss_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rss_pkg::t_cmd                     i_cmd,
    output rss_pkg::t_status                  o_status,
    input  logic signed [rss_pkg::SAMPLE_W-1:0] i_sample,
    output logic [rss_pkg::COUNT_W-1:0]       o_sample_count,
    output logic signed [rss_pkg::SAMPLE_W-1:0] o_minimum,
    output logic signed [rss_pkg::SAMPLE_W-1:0] o_maximum,
    output logic signed [rss_pkg::SUM_W-1:0]  o_total,
    output logic [rss_pkg::SQ_W-1:0]          o_square_total,
    output logic signed [rss_pkg::MEAN_W-1:0] o_mean_fixed,
    output logic [rss_pkg::VAR_W-1:0]         o_variance_fixed,
    output logic [rss_pkg::DEV_W-1:0]         o_deviation_fixed,
    output logic                              o_dropped
);
    import rss_pkg::*;

    // Run accumulators
    logic [COUNT_W-1:0]        r_cnt, n_cnt;
    logic signed [SAMPLE_W-1:0] r_min, n_min;
    logic signed [SAMPLE_W-1:0] r_max, n_max;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [SQ_W-1:0]           r_sq, n_sq;
    logic                      r_ovf, n_ovf;

    logic signed [2*SAMPLE_W-1:0] w_smp_sq;
    logic                         w_room;
    logic                         w_first;

    // Snapshot of the finished run and intermediate results
    logic [COUNT_W-1:0]         r_w_cnt;
    logic signed [SAMPLE_W-1:0] r_w_min;
    logic signed [SAMPLE_W-1:0] r_w_max;
    logic [SUM_W-1:0]           r_w_sum;
    logic [SQ_W-1:0]            r_w_sq;
    logic                       r_w_ovf;
    logic                       r_w_neg;
    logic [SUM_W-1:0]           r_w_mag;
    logic [PLO_W-1:0]           r_plo;
    logic [PHI_W-1:0]           r_phi;
    logic [SQR_W-1:0]           r_s2;
    logic [N2_W-1:0]            r_n2;
    logic [DIFF_W-1:0]          r_nss;
    logic [DIFF_W-1:0]          r_d;
    logic [MEAN_W-1:0]          r_w_mean;
    logic [VAR_W-1:0]           r_w_var;

    logic [DIFF_W:0]   w_diff;
    logic [DVD_W-1:0]  w_dvd;
    logic [DVS_W-1:0]  w_dvs;
    logic [DVD_W-1:0]  w_quo;
    logic [MEAN_W-1:0] w_q_mean;
    logic              w_div_busy;
    logic              w_sqrt_busy;
    logic [DEV_W-1:0]  w_root;

    // Result register
    logic [COUNT_W-1:0]         r_o_cnt;
    logic signed [SAMPLE_W-1:0] r_o_min;
    logic signed [SAMPLE_W-1:0] r_o_max;
    logic [SUM_W-1:0]           r_o_sum;
    logic [SQ_W-1:0]            r_o_sq;
    logic [MEAN_W-1:0]          r_o_mean;
    logic [VAR_W-1:0]           r_o_var;
    logic [DEV_W-1:0]           r_o_dev;
    logic                       r_o_ovf;

    assign w_smp_sq = i_sample * i_sample;
    assign w_room   = r_cnt < COUNT_W'(MAX_COUNT);
    assign w_first  = r_cnt == '0;

    always_comb begin
        n_cnt = r_cnt;
        n_min = r_min;
        n_max = r_max;
        n_sum = r_sum;
        n_sq  = r_sq;
        n_ovf = r_ovf;
        if (w_room) begin
            if (w_first) begin
                n_min = i_sample;
                n_max = i_sample;
            end else begin
                if (i_sample < r_min) begin
                    n_min = i_sample;
                end
                if (i_sample > r_max) begin
                    n_max = i_sample;
                end
            end
            n_cnt = r_cnt + COUNT_W'(1);
            n_sum = r_sum + SUM_W'(i_sample);
            n_sq  = r_sq + SQ_W'($unsigned(w_smp_sq));
        end else begin
            n_ovf = 1'b1;
        end
    end

    // Clear on the closing sample, advance on any other
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_min <= '0;
            r_max <= '0;
            r_sum <= '0;
            r_sq  <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.snap) begin
            r_cnt <= '0;
            r_min <= '0;
            r_max <= '0;
            r_sum <= '0;
            r_sq  <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.accum) begin
            r_cnt <= n_cnt;
            r_min <= n_min;
            r_max <= n_max;
            r_sum <= n_sum;
            r_sq  <= n_sq;
            r_ovf <= n_ovf;
        end
    end

    assign w_diff   = {1'b0, r_nss} - {1'b0, DIFF_W'(r_s2)};
    assign w_q_mean = w_quo[MEAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            r_w_cnt <= n_cnt;
            r_w_min <= n_min;
            r_w_max <= n_max;
            r_w_sum <= n_sum;
            r_w_sq  <= n_sq;
            r_w_ovf <= n_ovf;
        end
        if (i_cmd.prep) begin
            r_w_neg <= r_w_sum[SUM_W-1];
            r_w_mag <= r_w_sum[SUM_W-1] ? (~r_w_sum + SUM_W'(1)) : r_w_sum;
        end
        if (i_cmd.mul) begin
            r_plo <= PLO_W'(r_w_cnt) * PLO_W'(r_w_sq[SQ_LO_W-1:0]);
            r_phi <= PHI_W'(r_w_cnt) * PHI_W'(r_w_sq[SQ_W-1:SQ_LO_W]);
            r_s2  <= SQR_W'(r_w_mag) * SQR_W'(r_w_mag);
            r_n2  <= N2_W'(r_w_cnt) * N2_W'(r_w_cnt);
        end
        if (i_cmd.add) begin
            r_nss <= (DIFF_W'(r_phi) << SQ_LO_W) + DIFF_W'(r_plo);
        end
        if (i_cmd.sub) begin
            // Clamp a negative spread at zero
            r_d <= w_diff[DIFF_W] ? '0 : w_diff[DIFF_W-1:0];
        end
        if (i_cmd.take_mean) begin
            r_w_mean <= r_w_neg ? (~w_q_mean + MEAN_W'(1)) : w_q_mean;
        end
        if (i_cmd.take_var) begin
            r_w_var <= w_quo[VAR_W-1:0];
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_MEAN: begin
                w_dvd = DVD_W'(r_w_mag) << FRAC_BITS;
                w_dvs = DVS_W'(r_w_cnt);
            end
            DIV_VAR: begin
                w_dvd = DVD_W'(r_d) << FRAC_BITS;
                w_dvs = r_n2;
            end
            default: begin
                w_dvd = DVD_W'(r_w_mag) << FRAC_BITS;
                w_dvs = DVS_W'(r_w_cnt);
            end
        endcase
    end

    rss_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    rss_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (w_quo[VAR_W-1:0]),
        .o_busy     (w_sqrt_busy),
        .o_root     (w_root)
    );

    assign o_status.div_done  = !w_div_busy;
    assign o_status.sqrt_done = !w_sqrt_busy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_cnt  <= r_w_cnt;
            r_o_min  <= r_w_min;
            r_o_max  <= r_w_max;
            r_o_sum  <= r_w_sum;
            r_o_sq   <= r_w_sq;
            r_o_mean <= r_w_mean;
            r_o_var  <= r_w_var;
            r_o_dev  <= w_root;
            r_o_ovf  <= r_w_ovf;
        end
    end

    assign o_sample_count    = r_o_cnt;
    assign o_minimum         = r_o_min;
    assign o_maximum         = r_o_max;
    assign o_total           = r_o_sum;
    assign o_square_total    = r_o_sq;
    assign o_mean_fixed      = r_o_mean;
    assign o_variance_fixed  = r_o_var;
    assign o_deviation_fixed = r_o_dev;
    assign o_dropped         = r_o_ovf;

    `RSS_ASSERT_ALWAYS(a_count_limit, i_clk, i_rst_n, r_cnt <= COUNT_W'(MAX_COUNT), "run count past limit")
    `RSS_ASSERT_NEXT(a_snap_clears, i_clk, i_rst_n, i_cmd.snap, r_cnt == '0, "run not cleared after close")

endmodule

/* sv/rss_ctrl.sv */
// Controller: sequences accumulation, final arithmetic and result handoff.
`include "running_sample_statistics_defines.svh"
module rss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last,
    input  logic             i_out_ready,
    input  rss_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output rss_pkg::t_cmd    o_cmd
);
    import rss_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = r_state == ST_ACCUM;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.div_sel = DIV_MEAN;
        case (r_state)
            ST_ACCUM: begin
                if (i_in_valid) begin
                    o_cmd.accum = 1'b1;
                    if (i_last) begin
                        o_cmd.snap = 1'b1;
                        n_state    = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul       = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MEAN;
                n_state         = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_SUB;
            end
            ST_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = ST_MEAN;
            end
            ST_MEAN: begin
                if (i_status.div_done) begin
                    o_cmd.take_mean = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_VAR;
                    n_state         = ST_VAR;
                end
            end
            ST_VAR: begin
                o_cmd.div_sel = DIV_VAR;
                if (i_status.div_done) begin
                    o_cmd.take_var   = 1'b1;
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (i_status.sqrt_done && w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    `RSS_ASSERT_NEXT(a_close_stalls, i_clk, i_rst_n, i_in_valid && o_in_ready && i_last, !o_in_ready, "input open after run close")
    `RSS_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, o_cmd.div_start, i_status.div_done, "divider restarted while busy")
    `RSS_ASSERT_IMP(a_sqrt_idle, i_clk, i_rst_n, o_cmd.sqrt_start, i_status.sqrt_done, "root unit restarted while busy")

endmodule

/* sv/running_sample_statistics.sv */
// Top level of the running sample statistics block.

// Samples stream in one per cycle on a valid/ready channel; each sample is
// folded into the run's count, minimum, maximum, sum and sum of squares in the
// cycle of its transfer. The sample marked last closes the run: the totals are
// captured and the accumulators clear, after which the input stalls while the
// mean, variance and deviation are worked out by the bit-serial divider (used
// once for the mean and once for the variance) and the root unit.
// The result then sits in an output register; the next run accumulates while
// it waits to be taken, and only a second closing sample waits on it. A run
// holds at most 65536 samples; later samples are dropped and the result's
// dropped flag is set, and a dropped sample marked last still closes the run.
// Mean, variance and deviation carry 8 fraction bits: the mean truncates toward
// zero, a negative variance clamps to zero, and the deviation is a floor root.
module running_sample_statistics (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [rss_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rss_pkg::COUNT_W-1:0]         o_sample_count,
    output logic signed [rss_pkg::SAMPLE_W-1:0] o_minimum,
    output logic signed [rss_pkg::SAMPLE_W-1:0] o_maximum,
    output logic signed [rss_pkg::SUM_W-1:0]    o_total,
    output logic [rss_pkg::SQ_W-1:0]            o_square_total,
    output logic signed [rss_pkg::MEAN_W-1:0]   o_mean_fixed,
    output logic [rss_pkg::VAR_W-1:0]           o_variance_fixed,
    output logic [rss_pkg::DEV_W-1:0]           o_deviation_fixed,
    output logic                                o_dropped
);
    import rss_pkg::*;

    // Commands from the sequencer, done flags back from the arithmetic units
    t_cmd    w_cmd;
    t_status w_status;

    rss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_last),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // Accumulators, multiplies, divider, root unit and the result register
    rss_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_sample          (i_sample),
        .o_sample_count    (o_sample_count),
        .o_minimum         (o_minimum),
        .o_maximum         (o_maximum),
        .o_total           (o_total),
        .o_square_total    (o_square_total),
        .o_mean_fixed      (o_mean_fixed),
        .o_variance_fixed  (o_variance_fixed),
        .o_deviation_fixed (o_deviation_fixed),
        .o_dropped         (o_dropped)
    );

endmodule
